// ===== rtl/core/mppt_pkg.sv =====
// Shared types and constants of the perturb-and-observe tracker.
`default_nettype none
package mppt_pkg;

  // Field and register widths
  localparam int CfgW    = 12;
  localparam int CfgIdxW = 3;
  localparam int SampleW = 16;
  localparam int PowerW  = 32;
  localparam int StepW   = 13;
  localparam int RunW    = 3;

  // Run length after which the step may grow
  localparam logic [RunW-1:0] RunLimit = 3'd7;

  // Reset values of the configuration registers and of the step
  localparam logic [CfgW-1:0]  DacLowRst   = 12'd0;
  localparam logic [CfgW-1:0]  DacHighRst  = 12'd4095;
  localparam logic [CfgW-1:0]  StepLowRst  = 12'd1;
  localparam logic [CfgW-1:0]  StepHighRst = 12'd8;
  localparam logic [StepW-1:0] StepRst     = 13'd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgDacLow    = 3'd0,
    CfgDacHigh   = 3'd1,
    CfgStepLow   = 3'd2,
    CfgStepHigh  = 3'd3,
    CfgStrictLow = 3'd4
  } cfg_idx_e;

  // Configuration register file contents
  typedef struct packed {
    logic [CfgW-1:0] dac_low;
    logic [CfgW-1:0] dac_high;
    logic [CfgW-1:0] step_low;
    logic [CfgW-1:0] step_high;
    logic            strict_lower;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/mppt_cfg_regs.sv =====
// Configuration register file of the tracker, write only.
`default_nettype none
module mppt_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mppt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mppt_pkg::CfgW-1:0]     cfg_wdata_i,
  output mppt_pkg::cfg_t                     cfg_o
);

  mppt_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mppt_pkg::cfg_idx_e'(cfg_idx_i))
        mppt_pkg::CfgDacLow:    cfg_d.dac_low      = cfg_wdata_i;
        mppt_pkg::CfgDacHigh:   cfg_d.dac_high     = cfg_wdata_i;
        mppt_pkg::CfgStepLow:   cfg_d.step_low     = cfg_wdata_i;
        mppt_pkg::CfgStepHigh:  cfg_d.step_high    = cfg_wdata_i;
        mppt_pkg::CfgStrictLow: cfg_d.strict_lower = cfg_wdata_i[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dac_low      <= mppt_pkg::DacLowRst;
      cfg_q.dac_high     <= mppt_pkg::DacHighRst;
      cfg_q.step_low     <= mppt_pkg::StepLowRst;
      cfg_q.step_high    <= mppt_pkg::StepHighRst;
      cfg_q.strict_lower <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/mppt_power_stage.sv =====
// Input stage: takes one sample pair and registers its signed power.
`default_nettype none
module mppt_power_stage (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [mppt_pkg::SampleW-1:0] shunt_sample_i,
  input  wire logic [mppt_pkg::SampleW-1:0]        bus_sample_i,
  output logic                                     pwr_valid_o,
  input  wire logic                                pwr_ready_i,
  output logic signed [mppt_pkg::PowerW-1:0]       power_o
);

  localparam int ProdW = 2 * mppt_pkg::SampleW + 1;

  logic                               vld_q, vld_d;
  logic signed [mppt_pkg::PowerW-1:0] power_q;
  logic signed [ProdW-1:0]            prod;
  logic                               accept;

  // Signed shunt times unsigned bus; the product fits in the power width
  assign prod = $signed({{(mppt_pkg::SampleW+1){shunt_sample_i[mppt_pkg::SampleW-1]}},
                         shunt_sample_i})
              * $signed({{(mppt_pkg::SampleW+1){1'b0}}, bus_sample_i});

  assign in_ready_o = !vld_q || pwr_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Advance the stage valid
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (pwr_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture the power of an accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      power_q <= $signed(prod[mppt_pkg::PowerW-1:0]);
    end
  end

  assign pwr_valid_o = vld_q;
  assign power_o     = power_q;

endmodule
`default_nettype wire

// ===== rtl/core/mppt_track_stage.sv =====
// Tracking stage: direction, step adaptation, drive update and result register.
`default_nettype none
module mppt_track_stage #(
  parameter int DAC_BITS = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mppt_pkg::cfg_t                      cfg_i,
  input  wire logic                                pwr_valid_i,
  output logic                                     pwr_ready_o,
  input  wire logic signed [mppt_pkg::PowerW-1:0]  power_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [DAC_BITS-1:0]                      dac_value_o,
  output logic                                     moving_up_o,
  output logic [mppt_pkg::StepW-1:0]               step_now_o
);

  localparam int StepW = mppt_pkg::StepW;
  localparam int RunW  = mppt_pkg::RunW;
  localparam int SumW  = ((DAC_BITS > StepW) ? DAC_BITS : StepW) + 2;

  // Tracker state; drive, direction and step double as the result register
  logic signed [mppt_pkg::PowerW-1:0] last_power_q;
  logic                               dir_q, dir_d;
  logic                               prev_dir_q, prev_dir_d;
  logic [RunW-1:0]                    run_q, run_d;
  logic [StepW-1:0]                   step_q, step_d;
  logic [DAC_BITS-1:0]                drive_q, drive_d;
  logic                               out_vld_q, out_vld_d;

  logic            commit;
  logic            fall;
  logic [RunW:0]   cnt;
  logic [DAC_BITS-1:0] low_lim, high_lim;
  logic [SumW-1:0] up_sum, floor_sum, down_diff;
  logic            move_down;

  assign pwr_ready_o = !out_vld_q || out_ready_i;
  assign commit      = pwr_valid_i && pwr_ready_o;

  assign low_lim  = DAC_BITS'(cfg_i.dac_low);
  assign high_lim = DAC_BITS'(cfg_i.dac_high);

  // Flip on falling power, then adapt the step
  always_comb begin
    fall       = power_i < last_power_q;
    dir_d      = fall ? !dir_q : dir_q;
    cnt        = fall ? '0 : ({1'b0, run_q} + 1'b1);
    step_d     = step_q;
    prev_dir_d = prev_dir_q;
    if (dir_d == prev_dir_q) begin
      if (cnt >= {1'b0, mppt_pkg::RunLimit}) begin
        if (step_q < {1'b0, cfg_i.step_high}) begin
          step_d = {step_q[StepW-2:0], 1'b0};
        end
        cnt = '0;
      end
    end else begin
      if (step_q > {1'b0, cfg_i.step_low}) begin
        step_d = step_q >> 1;
      end
      prev_dir_d = dir_d;
    end
    run_d = cnt[RunW-1:0];
  end

  // Move the drive by the step, saturating at the limits
  always_comb begin
    up_sum    = SumW'(drive_q) + SumW'(step_d);
    floor_sum = SumW'(step_d) + SumW'(low_lim);
    down_diff = SumW'(drive_q) - SumW'(step_d);
    move_down = cfg_i.strict_lower ? (SumW'(drive_q) > floor_sum)
                                   : (SumW'(drive_q) >= floor_sum);
    if (dir_d) begin
      drive_d = (up_sum < SumW'(high_lim)) ? DAC_BITS'(up_sum) : high_lim;
    end else begin
      drive_d = move_down ? DAC_BITS'(down_diff) : low_lim;
    end
  end

  // Hold the result until taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (commit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_power_q <= '0;
      dir_q        <= 1'b1;
      prev_dir_q   <= 1'b1;
      run_q        <= '0;
      step_q       <= mppt_pkg::StepRst;
      drive_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (commit) begin
        last_power_q <= power_i;
        dir_q        <= dir_d;
        prev_dir_q   <= prev_dir_d;
        run_q        <= run_d;
        step_q       <= step_d;
        drive_q      <= drive_d;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign dac_value_o = drive_q;
  assign moving_up_o = dir_q;
  assign step_now_o  = step_q;

`ifndef SYNTHESIS
  // A run of the limit length is always folded back to zero
  a_run_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != mppt_pkg::RunLimit)
    else $error("run count reached its limit");

  // The remembered direction follows the direction after every item
  a_prev_dir_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_dir_q == dir_q)
    else $error("previous direction out of step");

  // Falling power clears the run count
  a_fall_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && fall) |=> (run_q == '0))
    else $error("run count not cleared on falling power");

  // Every committed item shows up as a result
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_vld_q)
    else $error("committed item lost");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mppt_perturb_observe_adaptive_step_unit.sv =====
// Top level of the perturb-and-observe tracker with adaptive step.
//
// Usage:
//   s_axis carries one sample pair per item: signed shunt voltage and bus
//   voltage. m_axis returns one result per item: new DAC drive value,
//   direction flag and current step size. The cfg port writes the DAC
//   limits, step limits and lower-check mode; write it only while idle.
//   An accepted item passes the power register, then the tracking update
//   into the result register.
//   Throughput: one item per cycle while m_axis_tready is high; the tracking
//   update, which needs the previous item's state, is combinational.
//   Reset: direction up, run count and last power zero, step 1, drive 0,
//   limits at their reset values; no items are held.
//   Stall: a result waits in the output register while m_axis_tready is
//   low; the power register still takes one more item if it is empty, then
//   s_axis_tready drops until the result is taken.
`default_nettype none
module mppt_perturb_observe_adaptive_step_unit #(
  parameter int DAC_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [mppt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [mppt_pkg::CfgW-1:0]          cfg_wdata_i,
  // Sample items
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] shunt_sample, [31:16] bus_sample
  input  wire logic [2*mppt_pkg::SampleW-1:0]     s_axis_tdata,
  // Result items
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [DAC_BITS-1:0] dac_value, [DAC_BITS] moving_up, then step_now (13 bits), zero pad
  output logic [((DAC_BITS+mppt_pkg::StepW+1+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OutW = ((DAC_BITS + mppt_pkg::StepW + 1 + 7) / 8) * 8;

  mppt_pkg::cfg_t                       cfg;
  logic                                 pwr_valid, pwr_ready;
  logic signed [mppt_pkg::PowerW-1:0]   power;
  logic [DAC_BITS-1:0]                  dac_value;
  logic                                 moving_up;
  logic [mppt_pkg::StepW-1:0]           step_now;

  mppt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mppt_power_stage u_power (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .shunt_sample_i ($signed(s_axis_tdata[mppt_pkg::SampleW-1:0])),
    .bus_sample_i   (s_axis_tdata[2*mppt_pkg::SampleW-1:mppt_pkg::SampleW]),
    .pwr_valid_o    (pwr_valid),
    .pwr_ready_i    (pwr_ready),
    .power_o        (power)
  );

  mppt_track_stage #(
    .DAC_BITS (DAC_BITS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pwr_valid_i (pwr_valid),
    .pwr_ready_o (pwr_ready),
    .power_i     (power),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .dac_value_o (dac_value),
    .moving_up_o (moving_up),
    .step_now_o  (step_now)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = OutW'({step_now, moving_up, dac_value});

endmodule
`default_nettype wire
